>>> rtl/aaid_pkg.sv
// ----------------------------------------------------------------------------
// aaid_pkg
// Shared types, widths and codes for the area average image downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package aaid_pkg;

	// source store geometry
	localparam int MAX_SRC_WIDTH  = 1024;
	localparam int MAX_SRC_HEIGHT = 128;
	localparam int STORE_DEPTH    = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int STORE_AW       = $clog2(STORE_DEPTH);

	// field and register widths
	localparam int SW_W   = 11;
	localparam int SH_W   = 8;
	localparam int STEP_W = 21;
	localparam int ADDR_W = 17;
	localparam int PIX_W  = 32;
	localparam int DX_W   = 10;
	localparam int CIDX_W = 2;

	// fixed point datapath widths
	localparam int FRAC_W = 16;
	localparam int ONE_Q16 = 65536;
	localparam int POS_W  = DX_W + 1 + STEP_W;
	localparam int CELL_W = POS_W - FRAC_W;
	localparam int WT_W   = FRAC_W + 2;
	localparam int W_W    = 2 * FRAC_W + 1;
	localparam int WA_W   = W_W + 8;
	localparam int LIN_W  = SW_W + SH_W + 1;
	localparam int WS_W   = 41;
	localparam int AS_W   = WS_W + 8;
	localparam int CS_W   = AS_W + 8;
	localparam int DV_W   = CS_W + 2;

	// register indexes
	localparam logic [CIDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_STEP       = 2'd2;

	// operation codes
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	typedef struct packed {
		logic              operation;
		logic [ADDR_W-1:0] src_addr;
		logic [PIX_W-1:0]  pixel_in;
		logic [DX_W-1:0]   dest_x;
		logic [DX_W-1:0]   dest_y;
	} item_t;

	typedef struct packed {
		logic [SW_W-1:0]   src_width;
		logic [SH_W-1:0]   src_height;
		logic [STEP_W-1:0] step;
	} cfg_t;

endpackage

`default_nettype wire

>>> rtl/area_average_image_downscale_unit.sv
// ----------------------------------------------------------------------------
// area_average_image_downscale_unit
// Area average ARGB downscaler with a loadable source image store.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid / in_stall) carries one request: a load writes
//   pixel_in to the store at src_addr, a pixel request returns the box
//   average for dest_x, dest_y on the out channel (out_valid / out_stall).
//   Registers src_width, src_height, step are written via the cfg channel
//   (cfg_valid / cfg_ready, always ready); user writes only while idle (unchecked).
// Timing:
//   a two entry queue decouples acceptance from execution. A load writes the
//   store when it leaves the queue. A pixel request walks the source cells
//   that its box covers: each cell goes through weight, store read, multiply
//   and accumulate in a shared sequencer, then one restoring divider resolves
//   red, green, blue and alpha at one quotient bit per cycle.
// Reset:
//   queue and sequencer are emptied, registers take their default values;
//   the store contents stay undefined until loaded.
// Stall:
//   a result holds in the output register until taken; the queue keeps
//   accepting requests until its two entries are full.
// ----------------------------------------------------------------------------
`default_nettype none

module area_average_image_downscale_unit import aaid_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire                operation,
	input  wire [ADDR_W-1:0]   src_addr,
	input  wire [PIX_W-1:0]    pixel_in,
	input  wire [DX_W-1:0]     dest_x,
	input  wire [DX_W-1:0]     dest_y,
	output logic               out_valid,
	input  wire                out_stall,
	output logic [PIX_W-1:0]   pixel_out,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire [CIDX_W-1:0]   cfg_index,
	input  wire [STEP_W-1:0]   cfg_data
);

	cfg_t  cfg_q;
	item_t in_item;
	item_t q_item;
	logic  q_valid;
	logic  q_pop;

	assign cfg_ready = 1'b1;
	assign in_item   = '{operation: operation, src_addr: src_addr,
		pixel_in: pixel_in, dest_x: dest_x, dest_y: dest_y};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width  <= SW_W'(MAX_SRC_WIDTH);
			cfg_q.src_height <= SH_W'(MAX_SRC_HEIGHT);
			cfg_q.step       <= STEP_W'(ONE_Q16);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SRC_WIDTH:  cfg_q.src_width  <= cfg_data[SW_W-1:0];
				CFG_SRC_HEIGHT: cfg_q.src_height <= cfg_data[SH_W-1:0];
				CFG_STEP:       cfg_q.step       <= cfg_data;
				default: ;
			endcase
		end
	end

	aaid_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	aaid_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel_out (pixel_out)
	);

endmodule

`default_nettype wire

>>> rtl/aaid_front.sv
// ----------------------------------------------------------------------------
// aaid_front
// Input side: accepts requests and holds them in a two entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module aaid_front import aaid_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   in_valid,
	output logic  in_stall,
	input  item_t in_item,
	output logic  q_valid,
	output item_t q_item,
	input  wire   q_pop
);

	item_t       buf_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;

	// queue status
	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = buf_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (q_pop)
				rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_ptr_q] <= in_item;
	end

endmodule

`default_nettype wire

>>> rtl/aaid_back.sv
// ----------------------------------------------------------------------------
// aaid_back
// Execution side: source store, box walk with weighted sums, and a shared
// restoring divider for the three colour channels and alpha.
// ----------------------------------------------------------------------------
`default_nettype none

module aaid_back import aaid_pkg::*; (
	input  wire               clk,
	input  wire               arst_n,
	input  cfg_t              cfg,
	input  wire               q_valid,
	input  item_t             q_item,
	output logic              q_pop,
	output logic              out_valid,
	input  wire               out_stall,
	output logic [PIX_W-1:0]  pixel_out
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_BOX, ST_CHECK, ST_CELL, ST_MUL, ST_ACC,
		ST_DIV_SET, ST_DIV_STEP, ST_OUT
	} state_t;

	state_t state_q;

	logic [PIX_W-1:0]  mem [STORE_DEPTH];
	logic [PIX_W-1:0]  rd_q;
	logic              mem_we;
	logic              mem_re;
	logic [STORE_AW-1:0] rd_addr;

	logic [DX_W-1:0]   dx_q, dy_q;
	logic [POS_W-1:0]  x1_q, x2_q, y1_q, y2_q;
	logic [POS_W-1:0]  x1_c, x2_c, y1_c, y2_c;
	logic [CELL_W-1:0] i_q, j_q;
	logic [CELL_W-1:0] sx, ex, sy, ey;

	logic [W_W-1:0]    w_s1, w_s2;
	logic              inr_s1;
	logic [WA_W-1:0]   wa_s2;
	logic [23:0]       c_s2;

	logic [WS_W-1:0]   wsum_q;
	logic [AS_W-1:0]   asum_q;
	logic [CS_W-1:0]   rsum_q, gsum_q, bsum_q;

	logic [1:0]        sel_q;
	logic [DV_W-1:0]   n_q, d_q;
	logic [3:0]        k_q;
	logic [7:0]        qt_q;
	logic              zero_q;
	logic [7:0]        r_q, g_q, b_q;

	// coverage of one cell by a half open span
	function automatic logic signed [WT_W-1:0] edge_weight(
		input logic [CELL_W-1:0] idx,
		input logic [POS_W-1:0]  lo,
		input logic [POS_W-1:0]  hi
	);
		logic signed [WT_W-1:0] w;
		w = WT_W'(ONE_Q16);
		if (idx == lo[POS_W-1:FRAC_W])
			w = w - $signed({2'b00, lo[FRAC_W-1:0]});
		if (idx == hi[POS_W-1:FRAC_W])
			w = w - ($signed(WT_W'(ONE_Q16)) - $signed({2'b00, hi[FRAC_W-1:0]}));
		return w;
	endfunction

	// box corners
	assign x1_c = POS_W'(dx_q) * POS_W'(cfg.step);
	assign x2_c = (POS_W'(dx_q) + POS_W'(1)) * POS_W'(cfg.step);
	assign y1_c = POS_W'(dy_q) * POS_W'(cfg.step);
	assign y2_c = (POS_W'(dy_q) + POS_W'(1)) * POS_W'(cfg.step);
	assign sx = x1_q[POS_W-1:FRAC_W];
	assign ex = x2_q[POS_W-1:FRAC_W];
	assign sy = y1_q[POS_W-1:FRAC_W];
	assign ey = y2_q[POS_W-1:FRAC_W];

	// cell weight and store address
	logic signed [WT_W-1:0] xw, yw;
	logic [2*FRAC_W+1:0]    wprod;
	logic                   wpos;
	logic                   inr;
	logic [LIN_W-1:0]       lin;
	always_comb begin
		xw    = edge_weight(i_q, x1_q, x2_q);
		yw    = edge_weight(j_q, y1_q, y2_q);
		wpos  = (xw > 0) && (yw > 0);
		wprod = xw[FRAC_W:0] * yw[FRAC_W:0];
		inr   = (i_q < CELL_W'(cfg.src_width)) && (j_q < CELL_W'(cfg.src_height));
		lin   = LIN_W'(j_q[SH_W-1:0]) * LIN_W'(cfg.src_width) + LIN_W'(i_q[SW_W-1:0]);
	end

	// pixel read outside the image or for an uncovered cell counts as zero
	logic [PIX_W-1:0] px;
	assign px = inr_s1 ? rd_q : '0;

	// weighted colour products
	logic [AS_W-1:0] wr_p, wg_p, wb_p;
	always_comb begin
		wr_p = wa_s2 * c_s2[23:16];
		wg_p = wa_s2 * c_s2[15:8];
		wb_p = wa_s2 * c_s2[7:0];
	end

	// shared divider step
	logic [DV_W-1:0] shifted;
	logic            ge;
	logic            dv_done;
	logic [7:0]      dv_res;
	always_comb begin
		shifted = d_q << k_q;
		ge      = (n_q >= shifted);
		dv_done = 1'b0;
		dv_res  = qt_q;
		if (zero_q) begin
			dv_done = 1'b1;
			dv_res  = 8'd0;
		end else if (k_q == 4'd8) begin
			if (ge) begin
				dv_done = 1'b1;
				dv_res  = 8'hFF;
			end
		end else begin
			if (ge)
				dv_res = qt_q | (8'd1 << k_q[2:0]);
			dv_done = (k_q == 4'd0);
		end
	end

	// divider operands for the channel in turn
	logic [DV_W-1:0] num, den;
	always_comb begin
		unique case (sel_q)
			2'd0: begin num = DV_W'(rsum_q); den = DV_W'(asum_q); end
			2'd1: begin num = DV_W'(gsum_q); den = DV_W'(asum_q); end
			2'd2: begin num = DV_W'(bsum_q); den = DV_W'(asum_q); end
			default: begin num = DV_W'(asum_q); den = DV_W'(wsum_q); end
		endcase
	end

	assign q_pop   = (state_q == ST_IDLE) && q_valid;
	assign mem_we  = q_pop && (q_item.operation == OP_LOAD)
		&& (32'(q_item.src_addr) < STORE_DEPTH);
	assign mem_re  = (state_q == ST_CELL);
	assign rd_addr = STORE_AW'(lin);

	// source store
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[STORE_AW'(q_item.src_addr)] <= q_item.pixel_in;
		if (mem_re)
			rd_q <= mem[rd_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid && q_item.operation == OP_REQUEST) begin
						dx_q    <= q_item.dest_x;
						dy_q    <= q_item.dest_y;
						state_q <= ST_BOX;
					end
				end
				ST_BOX: begin
					x1_q    <= x1_c;
					x2_q    <= x2_c;
					y1_q    <= y1_c;
					y2_q    <= y2_c;
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (sx >= CELL_W'(cfg.src_width) || sy >= CELL_W'(cfg.src_height)) begin
						pixel_out <= '0;
						out_valid <= 1'b1;
						state_q   <= ST_OUT;
					end else begin
						i_q     <= sx;
						j_q     <= sy;
						wsum_q  <= '0;
						asum_q  <= '0;
						rsum_q  <= '0;
						gsum_q  <= '0;
						bsum_q  <= '0;
						state_q <= ST_CELL;
					end
				end
				ST_CELL: begin
					w_s1    <= wpos ? wprod[W_W-1:0] : '0;
					inr_s1  <= wpos && inr && (32'(lin) < STORE_DEPTH);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					w_s2    <= w_s1;
					wa_s2   <= w_s1 * px[31:24];
					c_s2    <= px[23:0];
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					wsum_q <= wsum_q + WS_W'(w_s2);
					asum_q <= asum_q + AS_W'(wa_s2);
					rsum_q <= rsum_q + CS_W'(wr_p);
					gsum_q <= gsum_q + CS_W'(wg_p);
					bsum_q <= bsum_q + CS_W'(wb_p);
					if (i_q == ex) begin
						if (j_q == ey) begin
							sel_q   <= 2'd0;
							state_q <= ST_DIV_SET;
						end else begin
							i_q     <= sx;
							j_q     <= j_q + CELL_W'(1);
							state_q <= ST_CELL;
						end
					end else begin
						i_q     <= i_q + CELL_W'(1);
						state_q <= ST_CELL;
					end
				end
				ST_DIV_SET: begin
					n_q     <= (num << 1) + den;
					d_q     <= den << 1;
					zero_q  <= (den == '0);
					k_q     <= 4'd8;
					qt_q    <= 8'd0;
					state_q <= ST_DIV_STEP;
				end
				ST_DIV_STEP: begin
					if (!zero_q && k_q != 4'd8 && ge)
						n_q <= n_q - shifted;
					qt_q <= dv_res;
					if (!dv_done)
						k_q <= (k_q == 4'd8) ? 4'd7 : k_q - 4'd1;
					else begin
						unique case (sel_q)
							2'd0: r_q <= dv_res;
							2'd1: g_q <= dv_res;
							2'd2: b_q <= dv_res;
							default: begin
								pixel_out <= {dv_res, r_q, g_q, b_q};
								out_valid <= 1'b1;
							end
						endcase
						if (sel_q == 2'd3)
							state_q <= ST_OUT;
						else begin
							sel_q   <= sel_q + 2'd1;
							state_q <= ST_DIV_SET;
						end
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
